[src/detection_decode_nms_top_defines.svh]
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DETECTION_DECODE_NMS_TOP_DEFINES_SVH
`define DETECTION_DECODE_NMS_TOP_DEFINES_SVH

// Same-cycle implication
`define DNMS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dnms check failed");

// Next-cycle implication
`define DNMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dnms check failed");

`endif

[src/dnms_pkg.sv]
package dnms_pkg;

    // Kept list geometry
    localparam int MAX_KEPT = 32;
    localparam int IDX_W    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W    = $clog2(MAX_KEPT + 1);

    // Field widths
    localparam int NORM_W    = 17;
    localparam int SLOT_W    = 5;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_W  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_H  = 3'd4;

    // Configuration reset values
    localparam logic [15:0] THRESHOLD_RST = 16'd45875;
    localparam logic [15:0] REGION_SZ_RST = 16'd10240;

    // Result kinds
    localparam logic [1:0] KIND_DECISION = 2'd0;
    localparam logic [1:0] KIND_KEPT     = 2'd1;
    localparam logic [1:0] KIND_EMPTY    = 2'd2;

    // Decision codes
    localparam logic [2:0] DEC_LOW_SCORE = 3'd0;
    localparam logic [2:0] DEC_OUTSIDE   = 3'd1;
    localparam logic [2:0] DEC_SUPPRESS  = 3'd2;
    localparam logic [2:0] DEC_APPEND    = 3'd3;
    localparam logic [2:0] DEC_REPLACE   = 3'd4;
    localparam logic [2:0] DEC_FULL      = 3'd5;

    // One kept-list entry as stored in memory
    typedef struct packed {
        logic [NORM_W-1:0] left;
        logic [NORM_W-1:0] top;
        logic [NORM_W-1:0] right;
        logic [NORM_W-1:0] bottom;
        logic [15:0]       score;
        logic [7:0]        class_id;
    } kept_entry_t;

    localparam int ENTRY_W = $bits(kept_entry_t);

endpackage

[src/dnms_ifs.sv]
// Candidate box channel
interface box_if import dnms_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic signed [15:0] box_right;
    logic signed [15:0] box_bottom;
    logic [15:0]        box_score;
    logic [7:0]         class_id;
    logic               frame_end;

    modport source (output valid, box_left, box_top, box_right, box_bottom,
                    box_score, class_id, frame_end, input ready);
    modport sink   (input valid, box_left, box_top, box_right, box_bottom,
                    box_score, class_id, frame_end, output ready);
endinterface

// Result channel
interface res_if import dnms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        result_kind;
    logic [2:0]        decision;
    logic [SLOT_W-1:0] slot;
    logic [NORM_W-1:0] norm_left;
    logic [NORM_W-1:0] norm_top;
    logic [NORM_W-1:0] norm_right;
    logic [NORM_W-1:0] norm_bottom;
    logic [15:0]       out_score;
    logic [7:0]        out_class;
    logic              last;

    modport source (output valid, result_kind, decision, slot, norm_left, norm_top,
                    norm_right, norm_bottom, out_score, out_class, last, input ready);
    modport sink   (input valid, result_kind, decision, slot, norm_left, norm_top,
                    norm_right, norm_bottom, out_score, out_class, last, output ready);
endinterface

// Configuration write channel
interface cfg_if import dnms_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/dnms_ram.sv]
// Simple dual-port RAM, one write and one registered read port
module dnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/detection_decode_nms_top.sv]
// Detection decode with greedy non-maximum suppression.
// Channels: box (candidate in, valid/ready), res (results out, valid/ready),
// cfg (register writes, index + data, always ready; write only while idle).
// Each candidate transaction gives one decision result. With frame_end set,
// the kept boxes follow in list order (or one empty-list result) and the list
// is cleared; last marks the final result of the candidate.
// Steps per candidate:
//   low score or outside: straight to its decision result
//   otherwise: four parallel bit-serial dividers, then the area, then a
//   pipelined IoU scan (one memory read a cycle); on a replace, compaction
//   (one entry a cycle); then the append unless suppressed, then the decision.
//   frame end: each kept entry is read, then output.
// The kept list lives in one memory of MAX_KEPT entries; its one read port
// sets the scan and compaction rate.
// A new candidate is taken as soon as the previous one has put its last
// result into the output register, even if that result still waits.
// A receiver stall holds the output register and pauses the sequencer when it next writes it.
// Reset empties the list and loads the register defaults; no clearing pass.
module detection_decode_nms_top import dnms_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    cfg_if.sink  cfg,
    box_if.sink  box,
    res_if.source res
);

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIV      = 4'd1;
    localparam logic [3:0] S_AREA     = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_SHIFT    = 4'd4;
    localparam logic [3:0] S_APPEND   = 4'd5;
    localparam logic [3:0] S_DEC      = 4'd6;
    localparam logic [3:0] S_EMPTY    = 4'd7;
    localparam logic [3:0] S_EMIT_RD  = 4'd8;
    localparam logic [3:0] S_EMIT_OUT = 4'd9;

    // Control state
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ov_reg, ov_next;
    logic             v1_reg, v1_next;
    logic             v2_reg, v2_next;
    logic             sh_v_reg, sh_v_next;
    logic [15:0]      thr_reg, rx_reg, ry_reg, rw_reg, rh_reg;

    // Candidate and datapath payload
    logic [15:0]             c_score_reg, c_score_next;
    logic [7:0]              c_class_reg, c_class_next;
    logic                    c_fend_reg, c_fend_next;
    logic                    c_zero_reg, c_zero_next;
    logic [2:0]              c_dec_reg, c_dec_next;
    logic [SLOT_W-1:0]       c_slot_reg, c_slot_next;
    logic [NORM_W-1:0]       rem_reg [4];
    logic [NORM_W-1:0]       rem_next [4];
    logic [NORM_W-1:0]       quo_reg [4];
    logic [NORM_W-1:0]       quo_next [4];
    logic [3:0]              div_cnt_reg, div_cnt_next;
    logic signed [35:0]      area_c_reg, area_c_next;
    logic [CNT_W-1:0]        scan_addr_reg, scan_addr_next;
    logic [IDX_W-1:0]        idx1_reg, idx1_next;
    logic [IDX_W-1:0]        idx2_reg, idx2_next;
    logic                    match2_reg, match2_next;
    logic signed [35:0]      inter2_reg, inter2_next;
    logic signed [35:0]      ak2_reg, ak2_next;
    logic [15:0]             ks2_reg, ks2_next;
    logic [CNT_W-1:0]        sh_rd_reg, sh_rd_next;
    logic [IDX_W-1:0]        sh_wa_reg, sh_wa_next;
    logic [CNT_W-1:0]        emit_reg, emit_next;

    // Output register
    logic [1:0]        o_kind_reg, o_kind_next;
    logic [2:0]        o_dec_reg, o_dec_next;
    logic [SLOT_W-1:0] o_slot_reg, o_slot_next;
    logic [NORM_W-1:0] o_norm_reg [4];
    logic [NORM_W-1:0] o_norm_next [4];
    logic [15:0]       o_score_reg, o_score_next;
    logic [7:0]        o_class_reg, o_class_next;
    logic              o_last_reg, o_last_next;

    // Memory port
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    kept_entry_t      ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;

    // Combinational helpers
    logic               box_acc, out_free;
    logic signed [17:0] d [4];
    logic [15:0]        lane_sz [4];
    logic [16:0]        lane_off [4];
    logic [3:0]         outside;
    logic [17:0]        trial [4];
    logic [NORM_W-1:0]  cand_norm [4];
    logic [NORM_W-1:0]  ix_lo, ix_hi, iy_lo, iy_hi;
    logic signed [17:0] iw, ih, cw, ch, kw, kh;
    logic signed [37:0] lhs3, rhs3;
    logic               hit3;
    kept_entry_t        cand_entry;

    dnms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEPT)
    ) u_kept_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = kept_entry_t'(ram_rdata_raw);

    assign box_acc   = box.valid && box.ready;
    assign out_free  = !ov_reg || res.ready;
    assign box.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // Lane setup: x lanes use region x/width, y lanes region y/height
    always_comb
    begin
        lane_sz[0]  = (rw_reg == 16'd0) ? 16'd1 : rw_reg;
        lane_sz[2]  = lane_sz[0];
        lane_sz[1]  = (rh_reg == 16'd0) ? 16'd1 : rh_reg;
        lane_sz[3]  = lane_sz[1];
        lane_off[0] = {1'b0, rx_reg};
        lane_off[2] = lane_off[0];
        lane_off[1] = {1'b0, ry_reg};
        lane_off[3] = lane_off[1];
        d[0] = 18'(box.box_left)   - 18'($signed({1'b0, lane_off[0]}));
        d[1] = 18'(box.box_top)    - 18'($signed({1'b0, lane_off[1]}));
        d[2] = 18'(box.box_right)  - 18'($signed({1'b0, lane_off[2]}));
        d[3] = 18'(box.box_bottom) - 18'($signed({1'b0, lane_off[3]}));
        for (int i = 0; i < 4; i++)
        begin
            outside[i] = (d[i] < 18'sd0) || (d[i] > $signed({2'b00, lane_sz[i]}));
            trial[i]   = {rem_reg[i], 1'b0};
            cand_norm[i] = quo_reg[i];
        end
    end

    // Overlap of candidate and the entry on the read port
    always_comb
    begin
        ix_lo = (cand_norm[0] > ram_rdata.left)   ? cand_norm[0] : ram_rdata.left;
        ix_hi = (cand_norm[2] < ram_rdata.right)  ? cand_norm[2] : ram_rdata.right;
        iy_lo = (cand_norm[1] > ram_rdata.top)    ? cand_norm[1] : ram_rdata.top;
        iy_hi = (cand_norm[3] < ram_rdata.bottom) ? cand_norm[3] : ram_rdata.bottom;
        iw = $signed({1'b0, ix_hi}) - $signed({1'b0, ix_lo});
        ih = $signed({1'b0, iy_hi}) - $signed({1'b0, iy_lo});
        kw = $signed({1'b0, ram_rdata.right})  - $signed({1'b0, ram_rdata.left});
        kh = $signed({1'b0, ram_rdata.bottom}) - $signed({1'b0, ram_rdata.top});
        cw = $signed({1'b0, cand_norm[2]}) - $signed({1'b0, cand_norm[0]});
        ch = $signed({1'b0, cand_norm[3]}) - $signed({1'b0, cand_norm[1]});
        // 2*inter > ac + ak - inter  <=>  3*inter > ac + ak
        lhs3 = 38'(inter2_reg) + 38'(inter2_reg) + 38'(inter2_reg);
        rhs3 = 38'(area_c_reg) + 38'(ak2_reg);
        hit3 = v2_reg && match2_reg && (lhs3 > rhs3);
        cand_entry.left     = cand_norm[0];
        cand_entry.top      = cand_norm[1];
        cand_entry.right    = cand_norm[2];
        cand_entry.bottom   = cand_norm[3];
        cand_entry.score    = c_score_reg;
        cand_entry.class_id = c_class_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ov_next        = ov_reg && !res.ready;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        sh_v_next      = sh_v_reg;
        c_score_next   = c_score_reg;
        c_class_next   = c_class_reg;
        c_fend_next    = c_fend_reg;
        c_zero_next    = c_zero_reg;
        c_dec_next     = c_dec_reg;
        c_slot_next    = c_slot_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;
        area_c_next    = area_c_reg;
        scan_addr_next = scan_addr_reg;
        idx1_next      = idx1_reg;
        idx2_next      = idx2_reg;
        match2_next    = match2_reg;
        inter2_next    = inter2_reg;
        ak2_next       = ak2_reg;
        ks2_next       = ks2_reg;
        sh_rd_next     = sh_rd_reg;
        sh_wa_next     = sh_wa_reg;
        emit_next      = emit_reg;
        o_kind_next    = o_kind_reg;
        o_dec_next     = o_dec_reg;
        o_slot_next    = o_slot_reg;
        o_norm_next    = o_norm_reg;
        o_score_next   = o_score_reg;
        o_class_next   = o_class_reg;
        o_last_next    = o_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[IDX_W-1:0];
        ram_wdata      = cand_entry;
        ram_re         = 1'b0;
        ram_raddr      = scan_addr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (box_acc)
                begin
                    c_score_next = box.box_score;
                    c_class_next = box.class_id;
                    c_fend_next  = box.frame_end;
                    c_slot_next  = '0;
                    div_cnt_next = '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        if (d[i] >= $signed({2'b00, lane_sz[i]}))
                        begin
                            rem_next[i] = 17'(d[i] - $signed({2'b00, lane_sz[i]}));
                            quo_next[i] = 17'd1;
                        end
                        else
                        begin
                            rem_next[i] = 17'(d[i]);
                            quo_next[i] = 17'd0;
                        end
                    end
                    if (box.box_score < thr_reg)
                    begin
                        c_dec_next  = DEC_LOW_SCORE;
                        c_zero_next = 1'b1;
                        state_next  = S_DEC;
                    end
                    else if (|outside)
                    begin
                        c_dec_next  = DEC_OUTSIDE;
                        c_zero_next = 1'b1;
                        state_next  = S_DEC;
                    end
                    else
                    begin
                        c_zero_next = 1'b0;
                        state_next  = S_DIV;
                    end
                end
            end

            // One quotient bit per lane per cycle
            S_DIV:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (trial[i] >= {2'b00, lane_sz[i]})
                    begin
                        rem_next[i] = 17'(trial[i] - {2'b00, lane_sz[i]});
                        quo_next[i] = {quo_reg[i][15:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[i] = trial[i][16:0];
                        quo_next[i] = {quo_reg[i][15:0], 1'b0};
                    end
                end
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'd15)
                begin
                    state_next = S_AREA;
                end
            end

            S_AREA:
            begin
                area_c_next    = cw * ch;
                scan_addr_next = '0;
                v1_next        = 1'b0;
                v2_next        = 1'b0;
                state_next     = S_SCAN;
            end

            // Read -> products -> compare, one entry per cycle
            S_SCAN:
            begin
                if (scan_addr_reg < cnt_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = scan_addr_reg[IDX_W-1:0];
                    v1_next        = 1'b1;
                    idx1_next      = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                else
                begin
                    v1_next = 1'b0;
                end
                v2_next     = v1_reg;
                idx2_next   = idx1_reg;
                match2_next = (ram_rdata.class_id == c_class_reg) &&
                              (iw > 18'sd0) && (ih > 18'sd0);
                inter2_next = iw * ih;
                ak2_next    = kw * kh;
                ks2_next    = ram_rdata.score;
                if (hit3)
                begin
                    v1_next = 1'b0;
                    v2_next = 1'b0;
                    if (c_score_reg > ks2_reg)
                    begin
                        c_dec_next  = DEC_REPLACE;
                        c_slot_next = SLOT_W'(idx2_reg);
                        sh_rd_next  = CNT_W'(idx2_reg) + 1'b1;
                        sh_v_next   = 1'b0;
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        c_dec_next = DEC_SUPPRESS;
                        state_next = S_DEC;
                    end
                end
                else if (!v1_reg && !v2_reg && scan_addr_reg >= cnt_reg)
                begin
                    c_dec_next = DEC_APPEND;
                    state_next = S_APPEND;
                end
            end

            // Compact: entry a moves to a-1
            S_SHIFT:
            begin
                if (sh_v_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = sh_wa_reg;
                    ram_wdata = ram_rdata;
                end
                if (sh_rd_reg < cnt_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = sh_rd_reg[IDX_W-1:0];
                    sh_v_next  = 1'b1;
                    sh_wa_next = IDX_W'(sh_rd_reg - 1'b1);
                    sh_rd_next = sh_rd_reg + 1'b1;
                end
                else
                begin
                    sh_v_next = 1'b0;
                    if (!sh_v_reg)
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = S_APPEND;
                    end
                end
            end

            S_APPEND:
            begin
                if (cnt_reg >= CNT_W'(MAX_KEPT))
                begin
                    c_dec_next = DEC_FULL;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[IDX_W-1:0];
                    ram_wdata = cand_entry;
                    cnt_next  = cnt_reg + 1'b1;
                end
                state_next = S_DEC;
            end

            S_DEC:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    o_kind_next  = KIND_DECISION;
                    o_dec_next   = c_dec_reg;
                    o_slot_next  = c_slot_reg;
                    for (int i = 0; i < 4; i++)
                    begin
                        o_norm_next[i] = c_zero_reg ? '0 : cand_norm[i];
                    end
                    o_score_next = c_score_reg;
                    o_class_next = c_class_reg;
                    o_last_next  = !c_fend_reg;
                    emit_next    = '0;
                    if (!c_fend_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = S_EMPTY;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end

            S_EMPTY:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    o_kind_next  = KIND_EMPTY;
                    o_dec_next   = DEC_LOW_SCORE;
                    o_slot_next  = '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        o_norm_next[i] = '0;
                    end
                    o_score_next = '0;
                    o_class_next = '0;
                    o_last_next  = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_IDLE;
                end
            end

            S_EMIT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = emit_reg[IDX_W-1:0];
                state_next = S_EMIT_OUT;
            end

            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    ov_next        = 1'b1;
                    o_kind_next    = KIND_KEPT;
                    o_dec_next     = DEC_LOW_SCORE;
                    o_slot_next    = SLOT_W'(emit_reg);
                    o_norm_next[0] = ram_rdata.left;
                    o_norm_next[1] = ram_rdata.top;
                    o_norm_next[2] = ram_rdata.right;
                    o_norm_next[3] = ram_rdata.bottom;
                    o_score_next   = ram_rdata.score;
                    o_class_next   = ram_rdata.class_id;
                    if (emit_reg + 1'b1 == cnt_reg)
                    begin
                        o_last_next = 1'b1;
                        cnt_next    = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        o_last_next = 1'b0;
                        emit_next   = emit_reg + 1'b1;
                        state_next  = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            sh_v_reg  <= 1'b0;
            thr_reg   <= THRESHOLD_RST;
            rx_reg    <= '0;
            ry_reg    <= '0;
            rw_reg    <= REGION_SZ_RST;
            rh_reg    <= REGION_SZ_RST;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            sh_v_reg  <= sh_v_next;
            // Register write transaction
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_THRESHOLD: thr_reg <= cfg.data;
                    REG_REGION_X:  rx_reg  <= cfg.data;
                    REG_REGION_Y:  ry_reg  <= cfg.data;
                    REG_REGION_W:  rw_reg  <= cfg.data;
                    REG_REGION_H:  rh_reg  <= cfg.data;
                    default:       ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        c_score_reg   <= c_score_next;
        c_class_reg   <= c_class_next;
        c_fend_reg    <= c_fend_next;
        c_zero_reg    <= c_zero_next;
        c_dec_reg     <= c_dec_next;
        c_slot_reg    <= c_slot_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        div_cnt_reg   <= div_cnt_next;
        area_c_reg    <= area_c_next;
        scan_addr_reg <= scan_addr_next;
        idx1_reg      <= idx1_next;
        idx2_reg      <= idx2_next;
        match2_reg    <= match2_next;
        inter2_reg    <= inter2_next;
        ak2_reg       <= ak2_next;
        ks2_reg       <= ks2_next;
        sh_rd_reg     <= sh_rd_next;
        sh_wa_reg     <= sh_wa_next;
        emit_reg      <= emit_next;
        o_kind_reg    <= o_kind_next;
        o_dec_reg     <= o_dec_next;
        o_slot_reg    <= o_slot_next;
        o_norm_reg    <= o_norm_next;
        o_score_reg   <= o_score_next;
        o_class_reg   <= o_class_next;
        o_last_reg    <= o_last_next;
    end

    // Result port
    assign res.valid       = ov_reg;
    assign res.result_kind = o_kind_reg;
    assign res.decision    = o_dec_reg;
    assign res.slot        = o_slot_reg;
    assign res.norm_left   = o_norm_reg[0];
    assign res.norm_top    = o_norm_reg[1];
    assign res.norm_right  = o_norm_reg[2];
    assign res.norm_bottom = o_norm_reg[3];
    assign res.out_score   = o_score_reg;
    assign res.out_class   = o_class_reg;
    assign res.last        = o_last_reg;

endmodule

[src/dnms_checker.sv]
`include "detection_decode_nms_top_defines.svh"

module dnms_checker import dnms_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [1:0]        res_kind,
    input logic [2:0]        res_decision,
    input logic [NORM_W-1:0] res_norm_left,
    input logic [NORM_W-1:0] res_norm_right,
    input logic              res_last
);

    // A stalled result stays offered
    `DNMS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)

    // Kept entries carry no decision code
    `DNMS_ASSERT_NOW(a_kept_dec, res_valid && res_kind == KIND_KEPT,
                     res_decision == DEC_LOW_SCORE)

    // Dropped candidates show zero corners
    `DNMS_ASSERT_NOW(a_drop_zero, res_valid && res_kind == KIND_DECISION &&
                     (res_decision == DEC_LOW_SCORE || res_decision == DEC_OUTSIDE),
                     res_norm_left == '0 && res_norm_right == '0)

    // Empty-list frame end closes the candidate
    `DNMS_ASSERT_NOW(a_empty_last, res_valid && res_kind == KIND_EMPTY, res_last)

endmodule

bind detection_decode_nms_top dnms_checker u_dnms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_kind       (res.result_kind),
    .res_decision   (res.decision),
    .res_norm_left  (res.norm_left),
    .res_norm_right (res.norm_right),
    .res_last       (res.last)
);

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import dnms_pkg::*;

    // Candidate box as driven on the input channel
    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic [15:0]        score;
        logic [7:0]         cls;
        logic               fend;
    } cand_t;

    // One result transaction
    typedef struct {
        logic [1:0]        kind;
        logic [2:0]        dec;
        logic [SLOT_W-1:0] slot;
        logic [NORM_W-1:0] l;
        logic [NORM_W-1:0] t;
        logic [NORM_W-1:0] r;
        logic [NORM_W-1:0] b;
        logic [15:0]       score;
        logic [7:0]        cls;
        logic              last;
    } outcome_t;

    logic clk;
    logic rst_n;

    cfg_if cfg ();
    box_if box ();
    res_if res ();

    detection_decode_nms_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .box   (box),
        .res   (res)
    );

    // Register copies used by the predictor
    logic [15:0] thr_q, reg_x, reg_y, reg_w, reg_h;

    // Predicted kept list
    logic [NORM_W-1:0] list_l [MAX_KEPT];
    logic [NORM_W-1:0] list_t [MAX_KEPT];
    logic [NORM_W-1:0] list_r [MAX_KEPT];
    logic [NORM_W-1:0] list_b [MAX_KEPT];
    logic [15:0]       list_score [MAX_KEPT];
    logic [7:0]        list_cls [MAX_KEPT];
    int                list_cnt;

    cand_t    cand_q [$];
    outcome_t outcome_q [$];
    cand_t    cur;

    int  accepted;
    int  results_seen;
    int  mismatches;
    int  strays;
    int  dec_seen [6];
    int  kept_seen;
    int  empty_seen;
    int  gap;
    int  stall;
    bit  quiet;
    bit  hold_off;
    bit  nxt_valid;
    bit  nxt_ready;

    always #4 clk = ~clk;

    // Map one corner into the region; returns 0 when outside 0..1.0
    function automatic bit map_corner(input logic signed [15:0] c, input logic [15:0] off,
                                      input logic [15:0] size, output logic [NORM_W-1:0] n);
        longint d;
        longint s;
        d = longint'(c) - longint'(off);
        s = (size == 0) ? 1 : longint'(size);
        n = '0;
        if (d < 0 || d > s)
            return 0;
        n = NORM_W'((d << 16) / s);
        return 1;
    endfunction

    // IoU > 0.5 test against kept entry k
    function automatic bit iou_hit(input logic [NORM_W-1:0] nl, nt, nr, nb, input int k);
        longint w, h, inter, uni;
        longint l1, t1, r1, b1, l2, t2, r2, b2;
        l1 = nl; t1 = nt; r1 = nr; b1 = nb;
        l2 = list_l[k]; t2 = list_t[k]; r2 = list_r[k]; b2 = list_b[k];
        w = ((r1 < r2) ? r1 : r2) - ((l1 > l2) ? l1 : l2);
        if (w <= 0)
            return 0;
        h = ((b1 < b2) ? b1 : b2) - ((t1 > t2) ? t1 : t2);
        if (h <= 0)
            return 0;
        inter = w * h;
        uni = (r1 - l1) * (b1 - t1) + (r2 - l2) * (b2 - t2) - inter;
        return (2 * inter > uni);
    endfunction

    // Work out the results of one accepted candidate and update the kept list
    function automatic void predict_nms(input cand_t c);
        outcome_t o;
        logic [NORM_W-1:0] nl, nt, nr, nb;
        bit ok;
        int hit;
        o.kind = KIND_DECISION;
        o.slot = '0;
        o.l = '0; o.t = '0; o.r = '0; o.b = '0;
        o.score = c.score;
        o.cls = c.cls;
        o.last = !c.fend;
        if (c.score < thr_q) begin
            o.dec = DEC_LOW_SCORE;
        end
        else begin
            ok = map_corner(c.left, reg_x, reg_w, nl);
            ok = map_corner(c.top, reg_y, reg_h, nt) && ok;
            ok = map_corner(c.right, reg_x, reg_w, nr) && ok;
            ok = map_corner(c.bottom, reg_y, reg_h, nb) && ok;
            if (!ok) begin
                o.dec = DEC_OUTSIDE;
            end
            else begin
                o.l = nl; o.t = nt; o.r = nr; o.b = nb;
                hit = list_cnt;
                for (int k = 0; k < list_cnt; k++) begin
                    if (list_cls[k] == c.cls && iou_hit(nl, nt, nr, nb, k)) begin
                        hit = k;
                        break;
                    end
                end
                if (hit < list_cnt && c.score <= list_score[hit]) begin
                    o.dec = DEC_SUPPRESS;
                end
                else begin
                    if (hit < list_cnt) begin
                        // erase and compact
                        for (int k = hit; k + 1 < list_cnt; k++) begin
                            list_l[k] = list_l[k+1];
                            list_t[k] = list_t[k+1];
                            list_r[k] = list_r[k+1];
                            list_b[k] = list_b[k+1];
                            list_score[k] = list_score[k+1];
                            list_cls[k] = list_cls[k+1];
                        end
                        list_cnt--;
                        o.dec = DEC_REPLACE;
                        o.slot = SLOT_W'(hit);
                    end
                    else begin
                        o.dec = DEC_APPEND;
                    end
                    if (list_cnt >= MAX_KEPT) begin
                        o.dec = DEC_FULL;
                    end
                    else begin
                        list_l[list_cnt] = nl;
                        list_t[list_cnt] = nt;
                        list_r[list_cnt] = nr;
                        list_b[list_cnt] = nb;
                        list_score[list_cnt] = c.score;
                        list_cls[list_cnt] = c.cls;
                        list_cnt++;
                    end
                end
            end
        end
        outcome_q.push_back(o);

        // frame end: dump the list, or one empty marker
        if (c.fend) begin
            if (list_cnt == 0) begin
                o.kind = KIND_EMPTY;
                o.dec = DEC_LOW_SCORE;
                o.slot = '0;
                o.l = '0; o.t = '0; o.r = '0; o.b = '0;
                o.score = '0;
                o.cls = '0;
                o.last = 1'b1;
                outcome_q.push_back(o);
            end
            for (int k = 0; k < list_cnt; k++) begin
                o.kind = KIND_KEPT;
                o.dec = DEC_LOW_SCORE;
                o.slot = SLOT_W'(k);
                o.l = list_l[k]; o.t = list_t[k]; o.r = list_r[k]; o.b = list_b[k];
                o.score = list_score[k];
                o.cls = list_cls[k];
                o.last = (k + 1 == list_cnt);
                outcome_q.push_back(o);
            end
            list_cnt = 0;
        end
    endfunction

    function automatic void cmp_field(input string nm, input longint e, input longint a);
        if (e != a) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%t result %0d: %s expected %0d got %0d", $realtime, results_seen,
                         nm, e, a);
        end
    endfunction

    // Check one result transaction against the oldest expectation
    function automatic void check_outcome();
        outcome_t e;
        if (outcome_q.size() == 0) begin
            strays++;
            if (strays <= 10)
                $display("%t unexpected result, kind %0d", $realtime, res.result_kind);
            return;
        end
        e = outcome_q.pop_front();
        cmp_field("result_kind", e.kind, res.result_kind);
        cmp_field("decision", e.dec, res.decision);
        cmp_field("slot", e.slot, res.slot);
        cmp_field("norm_left", e.l, res.norm_left);
        cmp_field("norm_top", e.t, res.norm_top);
        cmp_field("norm_right", e.r, res.norm_right);
        cmp_field("norm_bottom", e.b, res.norm_bottom);
        cmp_field("out_score", e.score, res.out_score);
        cmp_field("out_class", e.cls, res.out_class);
        cmp_field("last", e.last, res.last);
        if (res.result_kind == KIND_DECISION && res.decision <= DEC_FULL)
            dec_seen[res.decision]++;
        if (res.result_kind == KIND_KEPT)
            kept_seen++;
        if (res.result_kind == KIND_EMPTY)
            empty_seen++;
        results_seen++;
    endfunction

    // Candidate driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            box.valid <= 1'b0;
            gap = 0;
        end
        else begin
            nxt_valid = box.valid;
            if (box.valid && box.ready) begin
                predict_nms(cur);
                accepted++;
                nxt_valid = 0;
            end
            if (!nxt_valid) begin
                if (gap > 0)
                    gap--;
                else if (cand_q.size() > 0) begin
                    if (!quiet && $urandom_range(0, 6) == 0)
                        gap = $urandom_range(1, 13);
                    else begin
                        cur = cand_q.pop_front();
                        nxt_valid = 1;
                    end
                end
            end
            box.valid      <= nxt_valid;
            box.box_left   <= cur.left;
            box.box_top    <= cur.top;
            box.box_right  <= cur.right;
            box.box_bottom <= cur.bottom;
            box.box_score  <= cur.score;
            box.class_id   <= cur.cls;
            box.frame_end  <= cur.fend;
        end
    end

    // Result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res.ready <= 1'b0;
            stall = 0;
        end
        else begin
            if (res.valid && res.ready)
                check_outcome();
            if (hold_off)
                nxt_ready = 0;
            else if (stall > 0) begin
                stall--;
                nxt_ready = 0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 13) - 1;
                nxt_ready = 0;
            end
            else
                nxt_ready = 1;
            res.ready <= nxt_ready;
        end
    end

    // Long receiver hold-off while the kept list is being filled
    initial
    begin
        hold_off = 0;
        wait (accepted >= 40);
        @(negedge clk);
        hold_off = 1;
        repeat (700) @(negedge clk);
        hold_off = 0;
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic add_cand(input int l, t, r, b, s, c, input bit fe);
        cand_t x;
        x.left = 16'(l); x.top = 16'(t); x.right = 16'(r); x.bottom = 16'(b);
        x.score = 16'(s); x.cls = 8'(c); x.fend = fe;
        cand_q.push_back(x);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            REG_THRESHOLD: thr_q = val;
            REG_REGION_X:  reg_x = val;
            REG_REGION_Y:  reg_y = val;
            REG_REGION_W:  reg_w = val;
            REG_REGION_H:  reg_h = val;
            default: ;
        endcase
        cfg.valid <= 1'b0;
    endtask

    task automatic set_regs(input int thr, x, y, w, h);
        cfg_write(REG_THRESHOLD, 16'(thr));
        cfg_write(REG_REGION_X, 16'(x));
        cfg_write(REG_REGION_Y, 16'(y));
        cfg_write(REG_REGION_W, 16'(w));
        cfg_write(REG_REGION_H, 16'(h));
        @(negedge clk);
    endtask

    // Wait until every candidate is in and every result is out
    task automatic drain();
        do @(negedge clk);
        while (cand_q.size() > 0 || box.valid || outcome_q.size() > 0);
        repeat (200) @(negedge clk);
    endtask

    task automatic noise_cand(input bit fe);
        add_cand($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 255), fe);
    endtask

    // One frame of candidates, mostly in range, many of them overlapping
    task automatic rand_frame(input int n);
        int xl [$], yt [$], xr [$], yb [$];
        int a, b2, c, d, p, j, s, cl;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                noise_cand(i == n - 1);
                continue;
            end
            if (xl.size() > 0 && $urandom_range(0, 9) < 5) begin
                p = $urandom_range(0, xl.size() - 1);
                j = reg_w / 16 + 1;
                a = xl[p] + $urandom_range(0, j) - j / 2;
                c = xr[p] + $urandom_range(0, j) - j / 2;
                j = reg_h / 16 + 1;
                b2 = yt[p] + $urandom_range(0, j) - j / 2;
                d = yb[p] + $urandom_range(0, j) - j / 2;
                if (a < 0) a = 0;
                if (b2 < 0) b2 = 0;
                if (c > reg_w) c = reg_w;
                if (d > reg_h) d = reg_h;
            end
            else begin
                a = $urandom_range(0, reg_w);
                c = $urandom_range(a, reg_w);
                b2 = $urandom_range(0, reg_h);
                d = $urandom_range(b2, reg_h);
            end
            xl.push_back(a); xr.push_back(c); yt.push_back(b2); yb.push_back(d);
            s = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(thr_q, 65535);
            cl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2);
            add_cand(reg_x + a, reg_y + b2, reg_x + c, reg_y + d, s, cl, i == n - 1);
        end
    endtask

    task automatic rand_frames(input int total);
        int n;
        while (total > 0) begin
            n = $urandom_range(3, 12);
            if (n > total) n = total;
            rand_frame(n);
            total -= n;
        end
    endtask

    // Main sequence
    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg.valid = 0;
        cfg.index = '0;
        cfg.data = '0;
        box.valid = 0;
        res.ready = 0;
        quiet = 0;
        accepted = 0;
        results_seen = 0;
        mismatches = 0;
        strays = 0;
        kept_seen = 0;
        empty_seen = 0;
        list_cnt = 0;
        foreach (dec_seen[i]) dec_seen[i] = 0;
        cur = '{default: '0};
        thr_q = THRESHOLD_RST;
        reg_x = 0;
        reg_y = 0;
        reg_w = REGION_SZ_RST;
        reg_h = REGION_SZ_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed cases at the reset register values
        add_cand(0, 0, 10, 10, 0, 0, 1);                      // empty frame end
        add_cand(0, 0, 10240, 10240, 45874, 0, 0);            // just below threshold
        add_cand(0, 0, 10240, 10240, 45875, 0, 0);            // at threshold: append
        add_cand(0, 0, 10240, 10240, 45875, 0, 0);            // equal score: suppressed
        add_cand(0, 0, 10240, 10240, 65535, 0, 0);            // higher score: replace
        add_cand(0, 0, 10240, 10240, 50000, 255, 0);          // other class: append
        add_cand(-32768, 0, 100, 100, 50000, 1, 0);           // outside left
        add_cand(0, 0, 32767, 100, 50000, 1, 0);              // outside right
        add_cand(0, 0, 100, 10241, 50000, 1, 0);              // just past bottom
        add_cand(0, -1, 100, 100, 50000, 1, 0);               // just above top
        add_cand(0, 0, 100, 100, 50000, 0, 0);                // contained, low IoU: append
        add_cand(0, 0, 5120, 10240, 50000, 0, 0);             // IoU exactly half
        add_cand(0, 0, 6000, 10240, 46000, 0, 0);             // IoU above half, lower
        add_cand(100, 100, 100, 200, 50000, 2, 0);            // zero-width box
        add_cand(5000, 5000, 9000, 9000, 65535, 0, 1);        // frame end with list
        add_cand(0, 0, 0, 0, 65535, 255, 1);                  // one-entry frame
        drain();

        // Fill the list past capacity, with the long receiver hold-off
        set_regs(0, 0, 0, 10240, 10240);
        for (int i = 0; i < 35; i++)
            add_cand(0, 0, 640, 640, $urandom_range(0, 65535), i, i == 34);
        rand_frames(70);
        drain();

        set_regs(20000, 100, 300, 4000, 6000);
        rand_frames(80);
        for (int i = 0; i < 10; i++)
            noise_cand($urandom_range(0, 3) == 0);
        add_cand(0, 0, 0, 0, 0, 0, 1);
        drain();

        set_regs(65535, 0, 0, 1, 1);
        rand_frames(25);
        drain();

        set_regs(0, 65535, 65535, 65535, 65535);
        for (int i = 0; i < 10; i++)
            noise_cand(i == 9);
        drain();

        // Last part without idling
        set_regs(30000, 0, 0, 65535, 65535);
        quiet = 1;
        rand_frames(60);
        drain();

        $display("Ran %0d candidates, %0d results: low %0d outside %0d suppressed %0d",
                 accepted, results_seen, dec_seen[0], dec_seen[1], dec_seen[2]);
        $display("appended %0d replaced %0d full %0d, kept boxes %0d, empty frames %0d",
                 dec_seen[3], dec_seen[4], dec_seen[5], kept_seen, empty_seen);
        if (mismatches == 0 && strays == 0 && outcome_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/dnms_pkg.sv
src/dnms_ifs.sv
src/dnms_ram.sv
src/detection_decode_nms_top.sv
src/dnms_checker.sv
bench/tb.sv
